>>> rtl/t33h_pkg.sv
// Shared types and constants for the times-33 string hash bucket core.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package t33h_pkg;

	localparam int HASH_W     = 32;
	localparam int CHAR_W     = 8;
	localparam int BKT_W      = 16;
	localparam int HASH_SHIFT = 5;
	localparam int CNT_W      = $clog2(HASH_W);

	localparam logic [BKT_W-1:0] BKT_RESET = 16'd100;

	// key queue between front and back: two entries, one pointer bit
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} back_state_t;

endpackage

>>> rtl/t33h_front.sv
// Front end: accepts characters and keeps the running times-33 hash.
// Pushes the finished hash of each key into the key queue. Uses t33h_pkg.
`timescale 1ns / 1ps

module t33h_front
	import t33h_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAR_W-1:0] key_char,
	input  logic              key_end,
	input  q_status_t         q_stat,
	output logic              q_push,
	output logic [HASH_W-1:0] q_wdata
);

	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] hash_upd;
	logic              accept;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	// h*33 + c with c sign-extended
	assign hash_upd = {hash_q[HASH_W-HASH_SHIFT-1:0], {HASH_SHIFT{1'b0}}} + hash_q
		+ {{(HASH_W-CHAR_W){key_char[CHAR_W-1]}}, key_char};

	assign q_push  = accept && key_end;
	assign q_wdata = hash_upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (accept) begin
			hash_q <= key_end ? '0 : hash_upd;
		end
	end

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && key_end) |=> (hash_q == '0))
		else $error("running hash not cleared after last character");
`endif

endmodule

>>> rtl/t33h_queue.sv
// Two-entry key queue between the hash front end and the modulo back end.
// Register based; status travels as q_status_t from t33h_pkg.
`timescale 1ns / 1ps

module t33h_queue
	import t33h_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [HASH_W-1:0] wdata,
	input  logic              pop,
	output logic [HASH_W-1:0] rdata,
	output q_status_t         stat
);

	logic [HASH_W-1:0] mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rdata      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full))
		else $error("key queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && stat.empty))
		else $error("key queue underflow");
`endif

endmodule

>>> rtl/t33h_back.sv
// Back end: takes one key hash from the queue, reduces it modulo the bucket
// count one quotient bit per cycle, and holds the result in an output register.
// Uses t33h_pkg.
`timescale 1ns / 1ps

module t33h_back
	import t33h_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BKT_W-1:0]  bucket_count,
	input  q_status_t         q_stat,
	input  logic [HASH_W-1:0] q_rdata,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BKT_W-1:0]  bucket_index,
	output logic [HASH_W-1:0] full_hash
);

	back_state_t       state_q;
	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] dvd_q;
	logic [BKT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              oval_q;
	logic [BKT_W-1:0]  oidx_q;
	logic [HASH_W-1:0] ohash_q;

	logic [BKT_W:0]    trial;
	logic [BKT_W:0]    diff;
	logic [BKT_W-1:0]  rem_next;
	logic              slot_free;

	assign trial     = {rem_q, dvd_q[HASH_W-1]};
	assign diff      = trial - {1'b0, bucket_count};
	assign rem_next  = (trial >= {1'b0, bucket_count}) ? diff[BKT_W-1:0] : trial[BKT_W-1:0];
	assign slot_free = !oval_q || out_ready;
	assign q_pop     = (state_q == ST_IDLE) && !q_stat.empty;

	assign out_valid    = oval_q;
	assign bucket_index = oidx_q;
	assign full_hash    = ohash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			oval_q  <= 1'b0;
		end else begin
			if (state_q == ST_DONE && slot_free) begin
				oval_q <= 1'b1;
			end else if (out_ready) begin
				oval_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(HASH_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			hash_q <= q_rdata;
			dvd_q  <= q_rdata;
			rem_q  <= '0;
		end else if (state_q == ST_RUN) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
		end
		if (state_q == ST_DONE && slot_free) begin
			oidx_q  <= (bucket_count == '0) ? '0 : rem_q;
			ohash_q <= hash_q;
		end
	end

`ifndef SYNTHESIS
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && bucket_count != '0) |-> (rem_q < bucket_count))
		else $error("partial remainder not below bucket count");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(oval_q) && bucket_count != '0 |-> (oidx_q < bucket_count))
		else $error("bucket index out of range");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == ST_RUN))
		else $error("pop did not start a reduction");
`endif

endmodule

>>> rtl/times33_string_hash_bucket_core.sv
// Times-33 string hash with bucket index. A key arrives one signed character
// per item; characters are taken one per clock while the queue is not full,
// each updating the running hash as h*33 + c. The item marked key_end puts the
// key's 32-bit hash into a two-entry queue; a back end reduces it modulo
// bucket_count with a one-bit-per-cycle restoring remainder unit: queue pop, 32
// remainder steps, hand-off to the output register once free. Long keys stream
// at one character per cycle while results are taken; shorter keys are limited
// by that unit, with the queue absorbing short bursts. A bucket_count of 0 gives
// bucket_index 0. Write bucket_count only while no key is in flight.
// Depends on t33h_pkg, t33h_front, t33h_queue and t33h_back.
`timescale 1ns / 1ps

module times33_string_hash_bucket_core
	import t33h_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAR_W-1:0] key_char,
	input  logic              key_end,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BKT_W-1:0]  bucket_index,
	output logic [HASH_W-1:0] full_hash,
	input  logic              cfg_we,
	input  logic [BKT_W-1:0]  cfg_wdata
);

	logic [BKT_W-1:0]  bucket_count_q;
	q_status_t         q_stat;
	logic              q_push;
	logic              q_pop;
	logic [HASH_W-1:0] q_wdata;
	logic [HASH_W-1:0] q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BKT_RESET;
		end else if (cfg_we) begin
			bucket_count_q <= cfg_wdata;
		end
	end

	t33h_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.key_char (key_char),
		.key_end  (key_end),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	t33h_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	t33h_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.bucket_count (bucket_count_q),
		.q_stat       (q_stat),
		.q_rdata      (q_rdata),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bucket_index (bucket_index),
		.full_hash    (full_hash)
	);

endmodule

>>> verif/tb_times33_string_hash_bucket_core.sv
// Testbench for times33_string_hash_bucket_core: keys go in one character per item,
// and each bucket_index / full_hash result is checked against a times-33 predictor
// or a typed directed row's result. Depends on t33h_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_times33_string_hash_bucket_core;
	import t33h_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 95;
	localparam int DIR_ROWS     = 24;

	typedef struct packed {
		logic [BKT_W-1:0]  index;
		logic [HASH_W-1:0] hash;
	} bucket_result_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              typed;
		bucket_result_t    res;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [CHAR_W-1:0] key_char = '0;
	logic              key_end = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [BKT_W-1:0]  bucket_index;
	logic [HASH_W-1:0] full_hash;
	logic              cfg_we = 1'b0;
	logic [BKT_W-1:0]  cfg_wdata = '0;

	// predictor state
	logic [HASH_W-1:0] key_hash = '0;
	logic [BKT_W-1:0]  bucket_model = BKT_RESET;
	bucket_result_t    pending_results [$];
	int                mismatch_count = 0;
	logic              tx_calm = 1'b0;

	logic [CHAR_W-1:0] corner_chars [4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
	int unsigned       bucket_plan [9] = '{1, 65535, 0, 2, 3, 100, 256, 1000, 65534};

	// directed keys, all with the reset bucket count of 100
	stim_row_t directed_rows [DIR_ROWS] = '{
		'{8'd65,  1'b1, 1'b1, '{16'd65, 32'd65}},
		'{8'h7F,  1'b1, 1'b1, '{16'd27, 32'd127}},
		'{8'h80,  1'b1, 1'b1, '{16'd68, 32'hFFFF_FF80}},
		'{8'hFF,  1'b1, 1'b1, '{16'd95, 32'hFFFF_FFFF}},
		'{8'h00,  1'b1, 1'b1, '{16'd0,  32'd0}},
		'{8'h00,  1'b0, 1'b0, '0},
		'{8'h00,  1'b1, 1'b1, '{16'd0,  32'd0}},
		'{8'd1,   1'b0, 1'b0, '0},
		'{8'd2,   1'b1, 1'b1, '{16'd35, 32'd35}},
		'{8'hFF,  1'b0, 1'b0, '0},
		'{8'hFF,  1'b1, 1'b0, '0},
		'{8'h80,  1'b0, 1'b0, '0},
		'{8'h80,  1'b0, 1'b0, '0},
		'{8'h7F,  1'b1, 1'b0, '0},
		'{8'd104, 1'b0, 1'b0, '0},
		'{8'd97,  1'b0, 1'b0, '0},
		'{8'd115, 1'b0, 1'b0, '0},
		'{8'd104, 1'b1, 1'b0, '0},
		'{8'd120, 1'b0, 1'b0, '0},
		'{8'h00,  1'b0, 1'b0, '0},
		'{8'd121, 1'b1, 1'b0, '0},
		'{8'h7F,  1'b0, 1'b0, '0},
		'{8'h7F,  1'b0, 1'b0, '0},
		'{8'h7F,  1'b1, 1'b0, '0}
	};

	times33_string_hash_bucket_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key_char     (key_char),
		.key_end      (key_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bucket_index (bucket_index),
		.full_hash    (full_hash),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("** times33_string_hash_bucket_core: FAILED **");
		$finish;
	end

	// Fold one character into the running hash; return 1 with the result on key end.
	function automatic logic absorb_char(input logic [CHAR_W-1:0] ch, input logic last,
			output bucket_result_t r);
		logic [HASH_W-1:0] h;
		h = (key_hash << HASH_SHIFT) + key_hash + {{(HASH_W-CHAR_W){ch[CHAR_W-1]}}, ch};
		r = '0;
		if (!last) begin
			key_hash = h;
			return 1'b0;
		end
		r.hash  = h;
		r.index = (bucket_model == '0) ? '0 : BKT_W'(h % {16'd0, bucket_model});
		key_hash = '0;
		return 1'b1;
	endfunction

	// Present one character; return at the edge where it is taken.
	task automatic push_char(input logic [CHAR_W-1:0] ch, input logic last, input logic typed,
			input bucket_result_t typed_res);
		int gap;
		bucket_result_t r;
		gap = tx_calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		key_char <= ch;
		key_end  <= last;
		do @(posedge clk); while (!in_ready);
		if (absorb_char(ch, last, r))
			pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic set_bucket_count(input logic [BKT_W-1:0] count);
		cfg_we    <= 1'b1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
		bucket_model = count;
	endtask

	// hold until every key's result is out, then let the back end settle
	task automatic wait_idle();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int sent;
		int len;
		int pick;
		logic [CHAR_W-1:0] ch;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			push_char(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
				directed_rows[i].res);

		for (int p = 0; p < PHASES; p++) begin
			in_valid <= 1'b0;
			wait_idle();
			set_bucket_count(p < 9 ? BKT_W'(bucket_plan[p]) : BKT_W'($urandom_range(1, 65535)));
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(0, 9);
				if (pick < 7)
					len = $urandom_range(1, 6);
				else if (pick < 9)
					len = $urandom_range(7, 20);
				else
					len = $urandom_range(34, 60);
				tx_calm = ($urandom_range(0, 3) == 0);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 7) == 0)
						ch = corner_chars[$urandom_range(0, 3)];
					else
						ch = CHAR_W'($urandom_range(0, 255));
					push_char(ch, k == len - 1, 1'b0, '0);
					sent++;
				end
			end
		end

		in_valid <= 1'b0;
		wait_idle();
		if (pending_results.size() != 0) begin
			mismatch_count += pending_results.size();
			$display("%0d results never arrived", pending_results.size());
		end
		if (mismatch_count == 0) begin
			$display("** times33_string_hash_bucket_core: PASSED **");
		end else begin
			$display("** times33_string_hash_bucket_core: FAILED **");
		end
		$finish;
	end

	// result side: random stalls with occasional stall-free stretches
	initial begin : sink
		int stall;
		logic rx_calm;
		rx_calm = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 7) == 0)
				rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : check_result
		bucket_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: bucket_index %0d full_hash %08h",
						bucket_index, full_hash);
			end else begin
				want = pending_results.pop_front();
				if (bucket_index !== want.index) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("bucket_index mismatch: expected %0d got %0d (hash %08h)",
							want.index, bucket_index, want.hash);
				end
				if (full_hash !== want.hash) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("full_hash mismatch: expected %08h got %08h",
							want.hash, full_hash);
				end
			end
		end
	end

endmodule

>>> files.f
rtl/t33h_pkg.sv
rtl/t33h_front.sv
rtl/t33h_queue.sv
rtl/t33h_back.sv
rtl/times33_string_hash_bucket_core.sv
verif/tb_times33_string_hash_bucket_core.sv
